// File: src/rkc_pkg.sv
`timescale 1ns / 1ps

package rkc_pkg;

   localparam int PIX_W          = 8;
   localparam int CHANNELS       = 3;
   localparam int PROD_W         = 17;
   localparam int SUM_W          = 21;
   localparam int COEF_COUNT     = 25;
   localparam int COEF_TABLE_W   = COEF_COUNT * PIX_W;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int CFG_DIM_W      = 11;
   localparam int PIX_MAX        = 255;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MAX_KERNEL_DEF = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SHIFT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_WORD_0   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_WORD_1   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_WORD_2   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_WORD_3   = 3'd7;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef logic [CHANNELS*PIX_W-1:0] pixel_type;

   function automatic logic signed [PIX_W-1:0] coef_at(input logic [COEF_TABLE_W-1:0] tbl,
                                                       input int idx);
      logic signed [PIX_W-1:0] c;
      c = '0;
      if (idx >= 0 && idx < COEF_COUNT) begin
         c = $signed(tbl[idx*PIX_W +: PIX_W]);
      end
      return c;
   endfunction

endpackage

// File: src/rkc_req_if.sv
`timescale 1ns / 1ps

interface rkc_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source (output valid, output command, output in_red, output in_green,
                   output in_blue, input ready);
   modport sink (input valid, input command, input in_red, input in_green,
                 input in_blue, output ready);
endinterface

// File: src/rkc_rsp_if.sv
`timescale 1ns / 1ps

interface rkc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       frame_end;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output frame_end, input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input frame_end, output ready);
endinterface

// File: src/rkc_line_cell.sv
`timescale 1ns / 1ps

module rkc_line_cell #(
   parameter int DEPTH = rkc_pkg::MAX_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               en,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  logic [AW-1:0]      raddr,
   input  rkc_pkg::pixel_type wdata,
   output rkc_pkg::pixel_type rdata
);

   rkc_pkg::pixel_type mem [DEPTH];
   rkc_pkg::pixel_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (en) begin
         if (we && waddr == raddr) begin
            rdata_ff <= wdata;
         end else begin
            rdata_ff <= mem[raddr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/rkc_tap_cell.sv
`timescale 1ns / 1ps

module rkc_tap_cell #(
   parameter int K = rkc_pkg::MAX_KERNEL_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic                              shift_en,
   input  rkc_pkg::pixel_type                new_pix,
   input  logic                              row_ok,
   input  logic [K-1:0]                      col_ok,
   input  logic [K*rkc_pkg::PIX_W-1:0]       coef_row,
   output logic signed [rkc_pkg::SUM_W-1:0]  row_sum [rkc_pkg::CHANNELS]
);

   localparam int PW = rkc_pkg::PROD_W;
   localparam int SW = rkc_pkg::SUM_W;
   localparam int NC = rkc_pkg::CHANNELS;
   localparam int BW = rkc_pkg::PIX_W;

   rkc_pkg::pixel_type     win_ff [K];
   logic signed [PW-1:0]   prod_ff [K][NC];
   logic signed [PW-1:0]   prod_in [K][NC];
   logic signed [SW-1:0]   sum_ff [NC];
   logic signed [SW-1:0]   sum_in [NC];

   always_comb begin
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] cf;
      for (int b = 0; b < K; b++) begin
         for (int c = 0; c < NC; c++) begin
            px = PW'($signed({1'b0, win_ff[b][BW*c +: BW]}));
            cf = PW'($signed(coef_row[BW*b +: BW]));
            if (row_ok && col_ok[b]) begin
               prod_in[b][c] = px * cf;
            end else begin
               prod_in[b][c] = '0;
            end
         end
      end
      for (int c = 0; c < NC; c++) begin
         sum_in[c] = '0;
         for (int b = 0; b < K; b++) begin
            sum_in[c] = sum_in[c] + SW'(prod_ff[b][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int b = 0; b < K - 1; b++) begin
            win_ff[b] <= win_ff[b+1];
         end
         win_ff[K-1] <= new_pix;
      end
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign row_sum = sum_ff;

endmodule

// File: src/rgb_kernel_convolution_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// req_bus   in         command, in_red, in_green, in_blue
// rsp_bus   out        out_red, out_green, out_blue, frame_end
// csr_*     in         csr_we, csr_index, csr_wdata
//
// One beat is taken every cycle unless the output stalls; a window's result is built
// in turn by line store read, window shift, products, row sums and output.
// Output starts after radius * width + radius processed beats of a frame.
// Reset is synchronous; it clears counters and pipeline valids and sets config defaults.
// A stalled result register stalls the whole pipeline, including req_bus.ready.

module rgb_kernel_convolution_core #(
   parameter int MAX_WIDTH  = rkc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rkc_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_KERNEL = rkc_pkg::MAX_KERNEL_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   rkc_req_if.sink                            req_bus,
   rkc_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [rkc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rkc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int K     = MAX_KERNEL;
   localparam int KLAST = K - 1;
   localparam int RMAX  = KLAST / 2;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int LW    = $clog2(RMAX * (MAX_WIDTH + 1) + 1);
   localparam int BW    = rkc_pkg::PIX_W;
   localparam int SW    = rkc_pkg::SUM_W;
   localparam int NC    = rkc_pkg::CHANNELS;
   localparam int DW    = rkc_pkg::CFG_DIM_W;

   logic [DW-1:0]  cfg_width_ff;
   logic [DW-1:0]  cfg_height_ff;
   logic [1:0]     cfg_radius_ff;
   logic [3:0]     cfg_shift_ff;
   logic [63:0]    cfg_coef0_ff;
   logic [63:0]    cfg_coef1_ff;
   logic [63:0]    cfg_coef2_ff;
   logic [7:0]     cfg_coef3_ff;

   int w_c;
   int h_c;
   int r_c;
   int d_c;
   logic [LW-1:0] lat_c;

   logic [CW-1:0] in_col_ff;
   logic [RW-1:0] in_row_ff;
   logic          done_ff;
   logic [LW-1:0] cnt_ff;
   logic [CW-1:0] out_col_ff;
   logic [RW-1:0] out_row_ff;

   logic en;
   logic fire;
   logic proc;
   logic emit;
   logic last;
   logic [K-1:0] row_ok;
   logic [K-1:0] col_ok;
   rkc_pkg::pixel_type pix;

   logic               s1_valid_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   rkc_pkg::pixel_type s1_pix_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [K-1:0]       s1_row_ok_ff;
   logic [K-1:0]       s1_col_ok_ff;
   logic               s2_emit_ff;
   logic               s2_last_ff;
   logic [K-1:0]       s2_row_ok_ff;
   logic [K-1:0]       s2_col_ok_ff;
   logic               s3_emit_ff;
   logic               s3_last_ff;
   logic               s4_emit_ff;
   logic               s4_last_ff;

   logic               rsp_valid_ff;
   logic               rsp_last_ff;
   logic [NC*BW-1:0]   rsp_data_ff;
   logic [NC*BW-1:0]   rsp_data_in;

   logic [rkc_pkg::COEF_TABLE_W-1:0] coef_tbl;
   logic [K*BW-1:0]                  coef_row [K];
   rkc_pkg::pixel_type               line_rd [KLAST];
   logic signed [SW-1:0]             row_sum [K][NC];

   assign en   = !rsp_valid_ff || rsp_bus.ready;
   assign fire = req_bus.valid && en;
   assign req_bus.ready = en;
   assign coef_tbl = {cfg_coef3_ff, cfg_coef2_ff, cfg_coef1_ff, cfg_coef0_ff};

   always_comb begin
      w_c = int'(cfg_width_ff);
      if (w_c < 1) w_c = 1;
      if (w_c > MAX_WIDTH) w_c = MAX_WIDTH;
      h_c = int'(cfg_height_ff);
      if (h_c < 1) h_c = 1;
      if (h_c > MAX_HEIGHT) h_c = MAX_HEIGHT;
      r_c = int'(cfg_radius_ff);
      if (r_c < 1) r_c = 1;
      if (r_c > RMAX) r_c = RMAX;
      d_c   = 2 * r_c + 1;
      lat_c = LW'(r_c * w_c + r_c);
   end

   always_comb begin
      for (int a = 0; a < K; a++) begin
         for (int b = 0; b < K; b++) begin
            coef_row[a][BW*b +: BW] = rkc_pkg::coef_at(coef_tbl, (KLAST - a) * d_c + (KLAST - b));
         end
      end
   end

   always_comb begin
      int dy;
      int rr;
      proc = done_ff || (req_bus.command == rkc_pkg::CMD_PIXEL);
      emit = cnt_ff >= lat_c;
      last = (int'(out_row_ff) + 1 >= h_c) && (int'(out_col_ff) + 1 >= w_c);
      pix  = done_ff ? '0 : {req_bus.in_blue, req_bus.in_green, req_bus.in_red};
      for (int a = 0; a < K; a++) begin
         dy = a - KLAST + r_c;
         rr = int'(out_row_ff) + dy;
         row_ok[a] = (dy >= -r_c) && (dy <= r_c) && (rr >= 0) && (rr < h_c);
         rr = int'(out_col_ff) + dy;
         col_ok[a] = (dy >= -r_c) && (dy <= r_c) && (rr >= 0) && (rr < w_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= DW'(640);
         cfg_height_ff <= DW'(480);
         cfg_radius_ff <= 2'd1;
         cfg_shift_ff  <= '0;
         cfg_coef0_ff  <= '0;
         cfg_coef1_ff  <= '0;
         cfg_coef2_ff  <= '0;
         cfg_coef3_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rkc_pkg::CSR_IMAGE_WIDTH:   cfg_width_ff  <= csr_wdata[DW-1:0];
            rkc_pkg::CSR_IMAGE_HEIGHT:  cfg_height_ff <= csr_wdata[DW-1:0];
            rkc_pkg::CSR_KERNEL_RADIUS: cfg_radius_ff <= csr_wdata[1:0];
            rkc_pkg::CSR_SCALE_SHIFT:   cfg_shift_ff  <= csr_wdata[3:0];
            rkc_pkg::CSR_COEF_WORD_0:   cfg_coef0_ff  <= csr_wdata;
            rkc_pkg::CSR_COEF_WORD_1:   cfg_coef1_ff  <= csr_wdata;
            rkc_pkg::CSR_COEF_WORD_2:   cfg_coef2_ff  <= csr_wdata;
            rkc_pkg::CSR_COEF_WORD_3:   cfg_coef3_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (fire && proc) begin
         if (emit && last) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            done_ff    <= 1'b0;
            cnt_ff     <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            if (int'(in_col_ff) + 1 >= w_c) begin
               in_col_ff <= '0;
               if (!done_ff) begin
                  if (int'(in_row_ff) + 1 >= h_c) begin
                     done_ff <= 1'b1;
                  end else begin
                     in_row_ff <= in_row_ff + 1'b1;
                  end
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
            if (!emit) begin
               cnt_ff <= cnt_ff + 1'b1;
            end else if (int'(out_col_ff) + 1 >= w_c) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_emit_ff   <= 1'b0;
         s2_emit_ff   <= 1'b0;
         s3_emit_ff   <= 1'b0;
         s4_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= fire && proc;
         s1_emit_ff   <= fire && proc && emit;
         s2_emit_ff   <= s1_emit_ff;
         s3_emit_ff   <= s2_emit_ff;
         s4_emit_ff   <= s3_emit_ff;
         rsp_valid_ff <= s4_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_last_ff   <= last;
         s1_pix_ff    <= pix;
         s1_col_ff    <= in_col_ff;
         s1_row_ok_ff <= row_ok;
         s1_col_ok_ff <= col_ok;
         s2_last_ff   <= s1_last_ff;
         s2_row_ok_ff <= s1_row_ok_ff;
         s2_col_ok_ff <= s1_col_ok_ff;
         s3_last_ff   <= s2_last_ff;
         s4_last_ff   <= s3_last_ff;
         rsp_last_ff  <= s4_last_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   for (genvar k = 0; k < KLAST; k++) begin : g_line
      rkc_line_cell #(
         .DEPTH (MAX_WIDTH),
         .AW    (CW)
      ) u_line (
         .clock (clock),
         .en    (en),
         .we    (en && s1_valid_ff),
         .waddr (s1_col_ff),
         .raddr (in_col_ff),
         .wdata ((k == 0) ? s1_pix_ff : line_rd[(k == 0) ? 0 : k - 1]),
         .rdata (line_rd[k])
      );
   end

   for (genvar a = 0; a < K; a++) begin : g_row
      rkc_tap_cell #(
         .K (K)
      ) u_tap (
         .clock    (clock),
         .en       (en),
         .shift_en (en && s1_valid_ff),
         .new_pix  ((a == KLAST) ? s1_pix_ff : line_rd[(a == KLAST) ? 0 : KLAST - 1 - a]),
         .row_ok   (s2_row_ok_ff[a]),
         .col_ok   (s2_col_ok_ff),
         .coef_row (coef_row[a]),
         .row_sum  (row_sum[a])
      );
   end

   always_comb begin
      logic signed [SW-1:0] total;
      logic [SW-1:0]        v;
      for (int c = 0; c < NC; c++) begin
         total = '0;
         for (int a = 0; a < K; a++) begin
            total = total + row_sum[a][c];
         end
         v = SW'(total) >> cfg_shift_ff;
         if (total[SW-1]) begin
            rsp_data_in[BW*c +: BW] = '0;
         end else if (int'(v) > rkc_pkg::PIX_MAX) begin
            rsp_data_in[BW*c +: BW] = BW'(rkc_pkg::PIX_MAX);
         end else begin
            rsp_data_in[BW*c +: BW] = v[BW-1:0];
         end
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_red   = rsp_data_ff[BW-1:0];
   assign rsp_bus.out_green = rsp_data_ff[2*BW-1:BW];
   assign rsp_bus.out_blue  = rsp_data_ff[3*BW-1:2*BW];
   assign rsp_bus.frame_end = rsp_last_ff;

endmodule

// File: src/rkc_checker.sv
`timescale 1ns / 1ps

module rkc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_frame_end
);

   // The result register comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // A held result beat blocks new input beats.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while result beat is stalled");

   // A pending result is not dropped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_frame_end)))
      else $error("stalled result beat changed");

   // With the output free, the input is always open.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input closed while output is free");

endmodule

bind rgb_kernel_convolution_core rkc_checker u_rkc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_frame_end (rsp_bus.frame_end)
);
